[hdl/ack_retry_tracker_core_assert.svh]
// Assertion macros shared by the ack retry tracker modules.
`ifndef ACK_RETRY_TRACKER_CORE_ASSERT_SVH
`define ACK_RETRY_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every aclk edge outside reset.
`define ARTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("ack retry tracker assertion failed");
// Checked on every aclk edge, reset included.
`define ARTC_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("ack retry tracker assertion failed");
`else
`define ARTC_ASSERT(lbl, prop)
`define ARTC_ASSERT_NORST(lbl, prop)
`endif
`endif

[hdl/art_pkg.sv]
// Shared types and constants for the ack retry tracker.
package art_pkg;

    localparam int KIND_W     = 3;
    localparam int SEQ_W      = 16;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 31;
    localparam int RETRY_W    = 8;
    localparam int PCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - PCNT_W - SEQ_W - 1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 31'd100000;
    localparam logic [RETRY_W-1:0]   MAX_RETRIES_RESET = 8'd3;
    localparam logic [RETRY_W-1:0]   RETRY_SAT         = 8'hFF;
    localparam logic [SEQ_W-1:0]     SEQ_START         = 16'd1;
    localparam logic [SEQ_W-1:0]     SEQ_MAX           = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SENT     = 3'd0,
        KIND_ACK      = 3'd1,
        KIND_CHECK    = 3'd2,
        KIND_NEXT_SEQ = 3'd3,
        KIND_RESET    = 3'd4,
        KIND_QUERY    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY,
        ST_PICK_SCAN,
        ST_PICK_DRAIN,
        ST_EMIT_DROP,
        ST_EMIT_LAST
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic pick;
        logic apply;
        logic emit_drop;
        logic emit_last;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        kind_t in_kind;
        kind_t kind;
        logic  idx_last;
        logic  drop_one;
        logic  drop_any;
        logic  out_free;
    } sts_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [RETRY_W-1:0] retries;
        logic [TIME_W-1:0]  stamp;
        logic [SEQ_W-1:0]   seq;
    } entry_t;

endpackage

[hdl/art_ram.sv]
// Generic simple dual-port RAM with registered read data.
module art_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/art_ctrl.sv]
// Sequencing state machine for the ack retry tracker.
`include "ack_retry_tracker_core_assert.svh"
module art_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  art_pkg::sts_t sts,
    output art_pkg::cmd_t cmd
);

    import art_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   in_accept;

    // A new request is taken only between items.
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (sts.in_kind)
                        KIND_SENT, KIND_ACK, KIND_CHECK, KIND_QUERY: state_next = ST_SCAN;
                        default: state_next = ST_APPLY;
                    endcase
                end
            end
            ST_SCAN: begin
                if (sts.idx_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (sts.kind == KIND_CHECK && sts.drop_any) begin
                    state_next = ST_PICK_SCAN;
                end else begin
                    state_next = ST_EMIT_LAST;
                end
            end
            ST_PICK_SCAN: begin
                if (sts.idx_last) state_next = ST_PICK_DRAIN;
            end
            ST_PICK_DRAIN: begin
                state_next = ST_EMIT_DROP;
            end
            ST_EMIT_DROP: begin
                if (sts.out_free) begin
                    state_next = sts.drop_one ? ST_EMIT_LAST : ST_PICK_SCAN;
                end
            end
            ST_EMIT_LAST: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = in_accept;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
            end
            ST_PICK_SCAN: begin
                cmd.scan_rd = 1'b1;
                cmd.pick    = 1'b1;
            end
            ST_EMIT_DROP: begin
                cmd.emit_drop = sts.out_free;
            end
            ST_EMIT_LAST: begin
                cmd.emit_last = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Every abandoned sequence has been reported before the next request.
    `ARTC_ASSERT(a_idle_no_drops, (state_reg == ST_IDLE) |-> !sts.drop_any)
    // A result is only loaded when the output register can take it.
    `ARTC_ASSERT(a_emit_needs_room, (cmd.emit_drop || cmd.emit_last) |-> sts.out_free)
    // Only a timeout check produces abandoned-sequence results.
    `ARTC_ASSERT(a_drop_only_check, (state_reg == ST_EMIT_DROP) |-> (sts.kind == KIND_CHECK))

endmodule

[hdl/art_datapath.sv]
// Entry table, scan pipeline, counters and output register of the tracker.
`include "ack_retry_tracker_core_assert.svh"
module art_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [art_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [art_pkg::KIND_W-1:0]         s_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [art_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [art_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  art_pkg::cmd_t                      cmd,
    output art_pkg::sts_t                      sts
);

    import art_pkg::*;

    localparam int             IW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int             CW       = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0]  IDX_LAST = IW'(ENTRIES - 1);

    // Item and configuration registers.
    kind_t                  kind_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [RETRY_W-1:0]     max_retries_reg;
    logic [SEQ_W-1:0]       seq_cnt_reg;
    logic [SEQ_W-1:0]       seq_cnt_inc;

    // Table bookkeeping.
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [ENTRIES-1:0]     drop_reg, drop_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          drop_cnt_reg, drop_cnt_next;

    // Scan pipeline.
    logic [IW-1:0]          idx_reg;
    logic                   pipe_valid_reg;
    logic                   pipe_pick_reg;
    logic [IW-1:0]          pipe_idx_reg;

    // Scan results.
    logic                   found_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;
    logic                   best_found_reg;
    logic [SEQ_W-1:0]       best_seq_reg;
    logic [IW-1:0]          best_idx_reg;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_ok_reg;
    logic                   out_to_reg;
    logic [SEQ_W-1:0]       out_seq_reg;
    logic [PCNT_W-1:0]      out_cnt_reg;
    logic                   out_last_reg;

    // Entry memory ports.
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    entry_t                 ram_wdata;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                 rd_entry;

    // Per-entry decisions at the pipeline stage.
    logic                   pipe_entry_valid;
    logic                   seq_match;
    logic                   free_slot;
    logic [TIME_W-1:0]      age;
    logic                   expired;
    logic [RETRY_W-1:0]     retries_inc;
    logic                   give_up;
    logic                   check_hit;
    logic                   pick_hit;
    logic                   final_ok;

    art_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Compare stage: the entry read last cycle is judged here.
    assign pipe_entry_valid = pipe_valid_reg && valid_reg[pipe_idx_reg];
    assign seq_match  = pipe_entry_valid && !pipe_pick_reg && (rd_entry.seq == seq_reg);
    assign free_slot  = pipe_valid_reg && !pipe_pick_reg && !valid_reg[pipe_idx_reg];
    assign age        = now_reg - rd_entry.stamp;
    assign expired    = age > {1'b0, timeout_reg};
    assign retries_inc = (rd_entry.retries == RETRY_SAT) ? rd_entry.retries
                                                         : rd_entry.retries + 1'b1;
    assign give_up    = retries_inc >= max_retries_reg;
    assign check_hit  = pipe_entry_valid && !pipe_pick_reg && (kind_reg == KIND_CHECK)
                        && expired;
    assign pick_hit   = pipe_valid_reg && pipe_pick_reg && drop_reg[pipe_idx_reg]
                        && (!best_found_reg || (rd_entry.seq < best_seq_reg));

    assign seq_cnt_inc = (seq_cnt_reg == SEQ_MAX) ? SEQ_START : seq_cnt_reg + 1'b1;

    // Table updates and entry memory writes.
    always_comb begin
        valid_next    = valid_reg;
        drop_next     = drop_reg;
        count_next    = count_reg;
        drop_cnt_next = drop_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = pipe_idx_reg;
        ram_wdata     = '{retries: retries_inc, stamp: now_reg, seq: rd_entry.seq};

        // Expired entry: drop it once out of retries, else restamp it and bump its retry count.
        if (check_hit) begin
            if (give_up) begin
                valid_next[pipe_idx_reg] = 1'b0;
                drop_next[pipe_idx_reg]  = 1'b1;
                count_next               = count_reg - 1'b1;
                drop_cnt_next            = drop_cnt_reg + 1'b1;
            end else begin
                ram_we = 1'b1;
            end
        end

        if (cmd.apply) begin
            case (kind_reg)
                KIND_SENT: begin
                    if (!found_reg && free_found_reg) begin
                        valid_next[free_idx_reg] = 1'b1;
                        count_next = count_reg + 1'b1;
                        ram_we     = 1'b1;
                        ram_waddr  = free_idx_reg;
                        ram_wdata  = '{retries: '0, stamp: now_reg, seq: seq_reg};
                    end
                end
                KIND_ACK: begin
                    if (found_reg) begin
                        valid_next[hit_idx_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                    end
                end
                KIND_RESET: begin
                    valid_next = '0;
                    count_next = '0;
                end
                default: begin
                    valid_next = valid_reg;
                end
            endcase
        end

        // A reported sequence leaves the drop list.
        if (cmd.emit_drop) begin
            drop_next[best_idx_reg] = 1'b0;
            drop_cnt_next = drop_cnt_reg - 1'b1;
        end
    end

    // Ok flag of the closing result.
    always_comb begin
        case (kind_reg)
            KIND_SENT:     final_ok = !found_reg && free_found_reg;
            KIND_ACK:      final_ok = found_reg;
            KIND_QUERY:    final_ok = found_reg;
            KIND_NEXT_SEQ: final_ok = 1'b1;
            KIND_RESET:    final_ok = 1'b1;
            default:       final_ok = 1'b0;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            drop_reg        <= '0;
            count_reg       <= '0;
            drop_cnt_reg    <= '0;
            seq_cnt_reg     <= SEQ_START;
            timeout_reg     <= TIMEOUT_RESET;
            max_retries_reg <= MAX_RETRIES_RESET;
            idx_reg         <= '0;
            pipe_valid_reg  <= 1'b0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            drop_reg       <= drop_next;
            count_reg      <= count_next;
            drop_cnt_reg   <= drop_cnt_next;
            pipe_valid_reg <= cmd.scan_rd;

            if (cfg_valid) begin
                case (cfg_index)
                    CFG_TIMEOUT:     timeout_reg     <= cfg_data[TIMEOUT_W-1:0];
                    CFG_MAX_RETRIES: max_retries_reg <= cfg_data[RETRY_W-1:0];
                    default:         timeout_reg     <= timeout_reg;
                endcase
            end

            if (cmd.scan_rd) begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
            end

            if (cmd.apply && kind_reg == KIND_NEXT_SEQ) begin
                seq_cnt_reg <= seq_cnt_inc;
            end else if (cmd.apply && kind_reg == KIND_RESET) begin
                seq_cnt_reg <= SEQ_START;
            end

            if (cmd.load) begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                best_found_reg <= 1'b0;
            end else begin
                if (seq_match) found_reg <= 1'b1;
                if (free_slot && !free_found_reg) free_found_reg <= 1'b1;
                if (pick_hit) begin
                    best_found_reg <= 1'b1;
                end else if (cmd.emit_drop) begin
                    best_found_reg <= 1'b0;
                end
            end

            if (cmd.emit_drop || cmd.emit_last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= kind_t'(s_tuser);
            seq_reg  <= s_tdata[SEQ_W-1:0];
            now_reg  <= s_tdata[SEQ_W+TIME_W-1:SEQ_W];
        end
        pipe_pick_reg <= cmd.pick;
        pipe_idx_reg  <= idx_reg;
        if (seq_match) hit_idx_reg <= pipe_idx_reg;
        if (free_slot && !free_found_reg) free_idx_reg <= pipe_idx_reg;
        if (pick_hit) begin
            best_seq_reg <= rd_entry.seq;
            best_idx_reg <= pipe_idx_reg;
        end
        if (cmd.emit_drop) begin
            out_ok_reg   <= 1'b0;
            out_to_reg   <= 1'b1;
            out_seq_reg  <= best_seq_reg;
            out_cnt_reg  <= PCNT_W'(count_reg);
            out_last_reg <= 1'b0;
        end else if (cmd.emit_last) begin
            out_ok_reg   <= final_ok;
            out_to_reg   <= 1'b0;
            out_seq_reg  <= (kind_reg == KIND_NEXT_SEQ) ? seq_cnt_reg : '0;
            out_cnt_reg  <= PCNT_W'(count_reg);
            out_last_reg <= 1'b1;
        end
    end

    // Ports and status.
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, out_cnt_reg, out_seq_reg, out_ok_reg};
    assign m_tuser   = out_to_reg;
    assign m_tlast   = out_last_reg;

    assign sts.in_kind  = kind_t'(s_tuser);
    assign sts.kind     = kind_reg;
    assign sts.idx_last = (idx_reg == IDX_LAST);
    assign sts.drop_one = (drop_cnt_reg == CW'(1));
    assign sts.drop_any = (drop_cnt_reg != '0);
    assign sts.out_free = !out_valid_reg || m_tready;

    // The pending count never exceeds the table size.
    `ARTC_ASSERT(a_count_bound, count_reg <= CW'(ENTRIES))
    // A pick scan only runs while abandoned sequences wait to be reported.
    `ARTC_ASSERT(a_pick_has_drop, (pipe_valid_reg && pipe_pick_reg) |-> (drop_cnt_reg != '0))
    // The drop count and the drop flags agree, so every pick finds an entry.
    `ARTC_ASSERT(a_drop_found, cmd.emit_drop |-> best_found_reg)

endmodule

[hdl/ack_retry_tracker_core.sv]
// Top level of the ack retry tracker: controller, datapath and ports.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_tvalid/s_tready    s_tdata {now_us, seq}, s_tuser kind
//   m_       out        m_tvalid/m_tready    m_tdata {pad, pending_count, seq_out, ok},
//                                            m_tuser timed_out, m_tlast last
//   cfg_     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Sent, ack and query go through accept, one entry memory pass at one entry per
// cycle, drain, apply and emit. A timeout check adds, per abandoned sequence, a
// further lowest-sequence pass that finds it, a drain and its emit. Other kinds
// skip the pass. Reset clears all valid bits at once, with no clearing pass.
// A stalled m_ channel holds the block in its emit state; one result may wait
// in the output register while the next request is taken.
module ack_retry_tracker_core #(
    parameter int ENTRIES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input requests.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [art_pkg::S_TDATA_W-1:0]  s_tdata,   // seq[15:0], now_us[47:16]
    input  logic [art_pkg::KIND_W-1:0]     s_tuser,   // kind[2:0]
    // Results.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [art_pkg::M_TDATA_W-1:0]  m_tdata,   // ok[0], seq_out[16:1],
                                                      // pending_count[21:17], zero[23:22]
    output logic                           m_tuser,   // timed_out
    output logic                           m_tlast,   // last
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [art_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0] cfg_data
);

    import art_pkg::*;

    cmd_t cmd;
    sts_t sts;

    art_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    art_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
